@@ sv/ket_pkg.sv @@
// Package for the keyed entry table: sizes, operation codes and the
// command struct broadcast from the top level to every table cell.
// No dependencies.
package ket_pkg;

  localparam int CAPACITY   = 32;
  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  typedef struct packed {
    logic                  go;
    logic [1:0]            kind;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [CNT_W-1:0]      count;
  } ket_cmd_t;

endpackage

@@ sv/ket_cell.sv @@
// One slot of the keyed entry table: holds a key and a value, compares
// the broadcast key, passes the hit chain on and shifts down on delete.
// Depends on ket_pkg.
module ket_cell (
  input  logic                          clk,
  input  logic [ket_pkg::IDX_W-1:0]     idx,
  input  ket_pkg::ket_cmd_t             cmd,
  input  logic                          hit_in,
  output logic                          hit_out,
  output logic                          first,
  input  logic [ket_pkg::KEY_BITS-1:0]   next_key,
  input  logic [ket_pkg::VALUE_BITS-1:0] next_value,
  output logic [ket_pkg::KEY_BITS-1:0]   key_q,
  output logic [ket_pkg::VALUE_BITS-1:0] value_q
);
  import ket_pkg::*;

  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic                  occupied;
  logic                  match;
  logic [CNT_W-1:0]      idx_ext;

  assign idx_ext  = CNT_W'(idx);
  assign occupied = idx_ext < cmd.count;
  assign match    = occupied && (key_r == cmd.key);
  assign first    = match && !hit_in;
  assign hit_out  = hit_in || match;
  assign key_q    = key_r;
  assign value_q  = value_r;

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      case (cmd.kind)
        KIND_ADD: begin
          if (idx_ext == cmd.count) begin
            key_r   <= cmd.key;
            value_r <= cmd.value;
          end
        end
        KIND_DELETE: begin
          // every slot from the first match upward takes its upper neighbor
          if (hit_out) begin
            key_r   <= next_key;
            value_r <= next_value;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ sv/keyed_entry_table.sv @@
// Top level of the keyed entry table: command port, fill count, the row
// of table cells and the result register. Depends on ket_pkg, ket_cell.
//
// Each operation runs as follows: busy is high for the cycle after
// start is taken, while the key is compared in every cell at once and the
// first match is found by a hit chain that runs through the row of cells;
// a delete shifts the upper entries down in that same cycle. The result is
// presented for one cycle on the out_ ports with out_strobe high, in the
// cycle right after the busy cycle (out_strobe rises at the edge where busy
// falls), and the receiver cannot stall it. A new start can be taken in the
// strobe cycle. Add to a full table is dropped and flagged by
// out_add_dropped; a miss reports found low, position 0 and value 0.
module keyed_entry_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_kind,
  input  logic [ket_pkg::KEY_BITS-1:0]   in_key,
  input  logic [ket_pkg::VALUE_BITS-1:0] in_value_in,
  output logic                          out_strobe,
  output logic                          out_found,
  output logic [ket_pkg::IDX_W-1:0]     out_position,
  output logic [ket_pkg::VALUE_BITS-1:0] out_value_out,
  output logic [ket_pkg::CNT_W-1:0]     out_entry_count,
  output logic                          out_is_full,
  output logic                          out_is_empty,
  output logic                          out_add_dropped
);
  import ket_pkg::*;

  logic                  busy_r;
  logic [1:0]            kind_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [CNT_W-1:0]      count_r, count_nxt;

  logic                  strobe_r;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic [VALUE_BITS-1:0] vout_r, vout_nxt;
  logic                  dropped_r, dropped_nxt;

  ket_cmd_t              cmd;
  logic [CAPACITY:0]     hit_chain;
  logic [CAPACITY-1:0]   first;
  logic [KEY_BITS-1:0]   cell_key   [CAPACITY+1];
  logic [VALUE_BITS-1:0] cell_value [CAPACITY+1];
  logic                  any_hit;
  logic                  full;
  logic [IDX_W-1:0]      hit_pos;
  logic [VALUE_BITS-1:0] hit_value;

  assign cmd.go    = busy_r;
  assign cmd.kind  = kind_r;
  assign cmd.key   = key_r;
  assign cmd.value = value_r;
  assign cmd.count = count_r;

  assign hit_chain[0]         = 1'b0;
  assign cell_key[CAPACITY]   = '0;
  assign cell_value[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ket_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .cmd        (cmd),
      .hit_in     (hit_chain[i]),
      .hit_out    (hit_chain[i+1]),
      .first      (first[i]),
      .next_key   (cell_key[i+1]),
      .next_value (cell_value[i+1]),
      .key_q      (cell_key[i]),
      .value_q    (cell_value[i])
    );
  end

  assign any_hit = hit_chain[CAPACITY];
  assign full    = count_r == CNT_W'(CAPACITY);

  // first[] is one-hot or zero, so an AND-OR select is enough
  always_comb begin
    hit_pos   = '0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_pos   = hit_pos | ({IDX_W{first[i]}} & IDX_W'(i));
      hit_value = hit_value | ({VALUE_BITS{first[i]}} & cell_value[i]);
    end
  end

  always_comb begin
    count_nxt   = count_r;
    found_nxt   = 1'b0;
    pos_nxt     = '0;
    vout_nxt    = '0;
    dropped_nxt = 1'b0;
    case (kind_r)
      KIND_ADD: begin
        if (full) dropped_nxt = 1'b1;
        else      count_nxt   = count_r + CNT_W'(1);
      end
      KIND_DELETE: begin
        if (any_hit) begin
          found_nxt = 1'b1;
          pos_nxt   = hit_pos;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      KIND_LOOKUP: begin
        if (any_hit) begin
          found_nxt = 1'b1;
          pos_nxt   = hit_pos;
          vout_nxt  = hit_value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
      count_r  <= '0;
    end else begin
      strobe_r <= busy_r;
      if (busy_r) begin
        busy_r  <= 1'b0;
        count_r <= count_nxt;
      end else if (start) begin
        busy_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      kind_r  <= in_kind;
      key_r   <= in_key;
      value_r <= in_value_in;
    end
    if (busy_r) begin
      found_r   <= found_nxt;
      pos_r     <= pos_nxt;
      vout_r    <= vout_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  assign busy            = busy_r;
  assign out_strobe      = strobe_r;
  assign out_found       = found_r;
  assign out_position    = pos_r;
  assign out_value_out   = vout_r;
  assign out_entry_count = count_r;
  assign out_is_full     = count_r == CNT_W'(CAPACITY);
  assign out_is_empty    = count_r == '0;
  assign out_add_dropped = dropped_r;

endmodule

@@ tb/sv/keyed_table_checker.sv @@
// Checker for the keyed entry table: watches the command and result ports,
// keeps its own copy of the table and compares every result field.
// Depends on ket_pkg.
`timescale 1ns / 100ps

module keyed_table_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [1:0]                     in_kind,
  input  logic [ket_pkg::KEY_BITS-1:0]   in_key,
  input  logic [ket_pkg::VALUE_BITS-1:0] in_value_in,
  input  logic                           out_strobe,
  input  logic                           out_found,
  input  logic [ket_pkg::IDX_W-1:0]      out_position,
  input  logic [ket_pkg::VALUE_BITS-1:0] out_value_out,
  input  logic [ket_pkg::CNT_W-1:0]      out_entry_count,
  input  logic                           out_is_full,
  input  logic                           out_is_empty,
  input  logic                           out_add_dropped,
  output int                             mismatches,
  output int                             outstanding
);
  import ket_pkg::*;

  typedef struct packed {
    logic                  found;
    logic [IDX_W-1:0]      position;
    logic [VALUE_BITS-1:0] value_out;
    logic [CNT_W-1:0]      entry_count;
    logic                  is_full;
    logic                  is_empty;
    logic                  add_dropped;
  } table_reply_t;

  logic [KEY_BITS-1:0]   key_copy [CAPACITY];
  logic [VALUE_BITS-1:0] value_copy [CAPACITY];
  int                    entries_held;
  table_reply_t          replies_due [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Apply one operation to the local table and return the reply it should give.
  function automatic table_reply_t table_apply(input logic [1:0] kind,
                                               input logic [KEY_BITS-1:0] key,
                                               input logic [VALUE_BITS-1:0] value);
    table_reply_t r;
    int hit;
    r   = '0;
    hit = -1;
    if (kind == KIND_DELETE || kind == KIND_LOOKUP) begin
      for (int i = entries_held - 1; i >= 0; i--) begin
        if (key_copy[i] == key) hit = i;
      end
    end
    if (kind == KIND_ADD) begin
      if (entries_held >= CAPACITY) begin
        r.add_dropped = 1'b1;
      end else begin
        key_copy[entries_held]   = key;
        value_copy[entries_held] = value;
        entries_held++;
      end
    end else if (kind == KIND_DELETE && hit >= 0) begin
      r.found    = 1'b1;
      r.position = hit[IDX_W-1:0];
      // close the gap left by the removed entry
      for (int j = hit; j + 1 < entries_held; j++) begin
        key_copy[j]   = key_copy[j+1];
        value_copy[j] = value_copy[j+1];
      end
      entries_held--;
    end else if (kind == KIND_LOOKUP && hit >= 0) begin
      r.found     = 1'b1;
      r.position  = hit[IDX_W-1:0];
      r.value_out = value_copy[hit];
    end
    r.entry_count = entries_held[CNT_W-1:0];
    r.is_full     = (entries_held == CAPACITY);
    r.is_empty    = (entries_held == 0);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    table_reply_t want;
    if (!rst_n) begin
      entries_held = 0;
      replies_due.delete();
    end else begin
      if (out_strobe) begin
        if (replies_due.size() == 0) begin
          $error("result transfer with no operation outstanding");
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          check_field("found",       64'(want.found),       64'(out_found));
          check_field("position",    64'(want.position),    64'(out_position));
          check_field("value_out",   64'(want.value_out),   64'(out_value_out));
          check_field("entry_count", 64'(want.entry_count), 64'(out_entry_count));
          check_field("is_full",     64'(want.is_full),     64'(out_is_full));
          check_field("is_empty",    64'(want.is_empty),    64'(out_is_empty));
          check_field("add_dropped", 64'(want.add_dropped), 64'(out_add_dropped));
        end
      end
      if (start && !busy) replies_due.push_back(table_apply(in_kind, in_key, in_value_in));
    end
    outstanding = replies_due.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the keyed entry table testbench: clock, reset, command stimulus,
// watchdog and verdict. Depends on ket_pkg, keyed_entry_table and
// keyed_table_checker.
`timescale 1ns / 100ps

module testbench;
  import ket_pkg::*;

  localparam logic [1:0] KIND_UNUSED    = 2'd3;
  localparam int         TARGET_OPS     = 400;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         DRAIN_CYCLES   = 8;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  start       = 1'b0;
  logic [1:0]            in_kind     = KIND_LOOKUP;
  logic [KEY_BITS-1:0]   in_key      = '0;
  logic [VALUE_BITS-1:0] in_value_in = '0;

  logic                  busy;
  logic                  out_strobe;
  logic                  out_found;
  logic [IDX_W-1:0]      out_position;
  logic [VALUE_BITS-1:0] out_value_out;
  logic [CNT_W-1:0]      out_entry_count;
  logic                  out_is_full;
  logic                  out_is_empty;
  logic                  out_add_dropped;

  int mismatches;
  int outstanding;
  int stall_cycles = 0;
  int ops_sent     = 0;
  bit no_gaps      = 1'b0;

  always #4 clk = ~clk;

  keyed_entry_table u_top (
    .clk, .rst_n, .start, .busy, .in_kind, .in_key, .in_value_in,
    .out_strobe, .out_found, .out_position, .out_value_out,
    .out_entry_count, .out_is_full, .out_is_empty, .out_add_dropped
  );

  keyed_table_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_kind, .in_key, .in_value_in,
    .out_strobe, .out_found, .out_position, .out_value_out,
    .out_entry_count, .out_is_full, .out_is_empty, .out_add_dropped,
    .mismatches, .outstanding
  );

  // Nothing transferred on either side for too long: the block is hung.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happens, or after a random gap behind it.
  task automatic issue_op(input logic [1:0] kind, input logic [KEY_BITS-1:0] key,
                          input logic [VALUE_BITS-1:0] value);
    int gap;
    start       <= 1'b1;
    in_kind     <= kind;
    in_key      <= key;
    in_value_in <= value;
    // busy is a register, so its value mid-cycle holds at the next edge
    do @(negedge clk); while (busy);
    @(posedge clk);
    if (kind != KIND_UNUSED) ops_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_directed();
    issue_op(KIND_LOOKUP, 16'h0000, 32'h0);
    issue_op(KIND_DELETE, 16'h0000, 32'h0);
    issue_op(KIND_UNUSED, 16'h0000, 32'h0);
    issue_op(KIND_ADD,    16'h0000, 32'h0000_0000);
    issue_op(KIND_ADD,    16'hFFFF, 32'hFFFF_FFFF);
    issue_op(KIND_ADD,    16'h0000, 32'h5A5A_A5A5);   // duplicate key
    issue_op(KIND_ADD,    16'h1234, 32'h0000_0001);
    issue_op(KIND_LOOKUP, 16'h0000, 32'hFFFF_FFFF);
    issue_op(KIND_LOOKUP, 16'hFFFF, 32'h0);
    issue_op(KIND_LOOKUP, 16'h1234, 32'h0);
    issue_op(KIND_LOOKUP, 16'h7777, 32'h0);
    issue_op(KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    issue_op(KIND_DELETE, 16'h0000, 32'hFFFF_FFFF);   // first copy goes, rest shift
    issue_op(KIND_LOOKUP, 16'h0000, 32'h0);
    issue_op(KIND_DELETE, 16'h4321, 32'h0);
    issue_op(KIND_DELETE, 16'h1234, 32'h0);           // last entry
    issue_op(KIND_DELETE, 16'hFFFF, 32'h0);
    issue_op(KIND_DELETE, 16'h0000, 32'h0);
    issue_op(KIND_LOOKUP, 16'h0000, 32'h0);
    issue_op(KIND_ADD,    16'hAAAA, 32'hAAAA_AAAA);
    issue_op(KIND_ADD,    16'h5555, 32'h5555_5555);
  endtask

  // Bursts that fill, drain or mix, so the table swings between empty and full.
  task automatic run_random();
    int burst_len, fill_mode, pool_n, r, add_pct, del_pct;
    logic [KEY_BITS-1:0] pool_base, key;
    logic [1:0] kind;
    while (ops_sent < TARGET_OPS) begin
      burst_len = $urandom_range(20, 70);
      fill_mode = $urandom_range(0, 2);
      pool_n    = ($urandom_range(0, 1) == 0) ? 4 : 48;
      r         = $urandom_range(0, 2);
      pool_base = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFC0 : 16'($urandom);
      no_gaps   = ($urandom_range(0, 3) == 0);
      case (fill_mode)
        0: begin add_pct = 80; del_pct = 8;  end
        1: begin add_pct = 10; del_pct = 70; end
        default: begin add_pct = 35; del_pct = 30; end
      endcase
      repeat (burst_len) begin
        if (ops_sent >= TARGET_OPS) break;
        r = $urandom_range(0, 99);
        if (r < add_pct) kind = KIND_ADD;
        else if (r < add_pct + del_pct) kind = KIND_DELETE;
        else if (r < 98) kind = KIND_LOOKUP;
        else kind = KIND_UNUSED;
        if ($urandom_range(0, 9) == 0) key = 16'($urandom);
        else key = pool_base + 16'($urandom_range(0, pool_n - 1));
        issue_op(kind, key, $urandom);
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ keyed_entry_table.f @@
sv/ket_pkg.sv
sv/ket_cell.sv
sv/keyed_entry_table.sv
tb/sv/keyed_table_checker.sv
tb/sv/testbench.sv
